// ===== rtl/core/itow_pkg.sv =====
// itow_pkg: shared types and constants for the ip/tcp option walker
// used by itow_step and ip_tcp_option_walker_top; no dependencies

package itow_pkg;

   localparam int unsigned AREA_LEN_W  = 6;
   localparam int unsigned BYTE_W      = 8;

   localparam logic [AREA_LEN_W-1:0] MAX_AREA_BYTES = 6'd40;
   localparam logic [BYTE_W-1:0]     MIN_OPTION_LEN = 8'd2;

   localparam logic [BYTE_W-1:0] KIND_END = 8'd0;
   localparam logic [BYTE_W-1:0] KIND_PAD = 8'd1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_END     = 2'd1,
      STATUS_BADLEN  = 2'd2,
      STATUS_OVERRUN = 2'd3
   } walk_status_type;

   typedef enum logic [3:0] {
      PH_STOPPED = 4'b0001,
      PH_KIND    = 4'b0010,
      PH_LEN     = 4'b0100,
      PH_SKIP    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     data_byte;
      logic                  area_start;
      logic [AREA_LEN_W-1:0] area_length;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     option_kind;
      logic [BYTE_W-1:0]     option_length;
      logic [AREA_LEN_W-1:0] payload_offset;
      walk_status_type       walk_status;
   } rsp_item_type;

   typedef struct packed {
      phase_type             phase;
      logic [AREA_LEN_W-1:0] bytes_left;
      logic [AREA_LEN_W-1:0] position;
      logic [BYTE_W-1:0]     pending_kind;
      logic [BYTE_W-1:0]     skip_count;
   } walk_state_type;

endpackage

// ===== rtl/core/ip_tcp_option_walker_top.sv =====
// ip_tcp_option_walker_top: top level of the ip/tcp option walker
// depends on itow_pkg and itow_step
//
// usage
// - the req channel carries one byte of an ipv4 or tcp options area per item;
//   area_start marks the first byte of a new area and area_length gives its size
//   (values above 40 are clipped to 40)
// - the rsp channel carries at most one item per input item: the kind, total
//   length, data offset and status of an option, or an end / bad length /
//   overrun report that stops the walk
// - both channels move an item on a clock edge with valid high and stall low
// - the result appears on rsp in the cycle after its input is accepted
// - throughput: one input item per cycle while req_stall is low; the walk state
//   advances as the byte is taken; the result lands in a single output register
// - when the receiver stalls with a result held, req_stall rises and no new
//   item is taken until that result leaves; bytes with no result still wait
// - synchronous reset stops the walk and empties the output register; bytes
//   arriving before a start byte are dropped silently

module ip_tcp_option_walker_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itow_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itow_pkg::rsp_item_type rsp_data
);

   itow_pkg::walk_state_type state_ff;
   itow_pkg::walk_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   itow_pkg::rsp_item_type   rsp_data_ff;
   itow_pkg::rsp_item_type   rsp_data_in;
   logic                     step_emit;
   itow_pkg::rsp_item_type   step_result;
   itow_pkg::walk_state_type step_state;
   logic                     req_accept;

   // per-byte decode of kind, length and skip
   itow_step u_step (
      .cur_state  (state_ff),
      .item       (req_data),
      .next_state (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   // held result blocks new items only while the receiver stalls it
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         state_in     = step_state;
         rsp_valid_in = step_emit;
         if (step_emit) begin
            rsp_data_in = step_result;
         end
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= itow_pkg::PH_STOPPED;
         state_ff.bytes_left   <= '0;
         state_ff.position     <= '0;
         state_ff.pending_kind <= '0;
         state_ff.skip_count   <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/itow_step.sv =====
// itow_step: next walk state and result for one options byte
// depends on itow_pkg

module itow_step (
   input  itow_pkg::walk_state_type cur_state,
   input  itow_pkg::req_item_type   item,
   output itow_pkg::walk_state_type next_state,
   output logic                     emit,
   output itow_pkg::rsp_item_type   result
);

   itow_pkg::walk_state_type        base;
   logic [itow_pkg::AREA_LEN_W-1:0] alen_sat;
   logic [itow_pkg::AREA_LEN_W:0]   avail;
   logic [itow_pkg::BYTE_W-1:0]     skip_dec;
   logic [itow_pkg::BYTE_W-1:0]     b;

   assign b        = item.data_byte;
   assign alen_sat = (item.area_length > itow_pkg::MAX_AREA_BYTES)
                     ? itow_pkg::MAX_AREA_BYTES : item.area_length;
   assign avail    = {1'b0, base.bytes_left} + 7'd1;
   assign skip_dec = (base.skip_count != 8'd0) ? base.skip_count - 8'd1 : 8'd0;

   // a start byte reloads the walk before the byte itself is looked at
   always_comb begin
      if (item.area_start) begin
         base.phase        = itow_pkg::PH_KIND;
         base.bytes_left   = alen_sat;
         base.position     = '0;
         base.pending_kind = '0;
         base.skip_count   = '0;
      end else begin
         base = cur_state;
      end
   end

   always_comb begin
      next_state = base;
      emit       = 1'b0;
      result     = '{option_kind: '0, option_length: '0, payload_offset: '0,
                     walk_status: itow_pkg::STATUS_OK};
      case (base.phase)
         itow_pkg::PH_KIND: begin
            if (base.bytes_left == '0) begin
               next_state.phase = itow_pkg::PH_STOPPED;
            end else if (b == itow_pkg::KIND_END) begin
               next_state.phase   = itow_pkg::PH_STOPPED;
               emit               = 1'b1;
               result.walk_status = itow_pkg::STATUS_END;
            end else if (b == itow_pkg::KIND_PAD) begin
               next_state.position   = base.position + 6'd1;
               next_state.bytes_left = base.bytes_left - 6'd1;
               emit                  = 1'b1;
               result.option_kind    = b;
               result.option_length  = 8'd1;
            end else if (base.bytes_left < 6'd2) begin
               // kind byte last in the area
               next_state.phase   = itow_pkg::PH_STOPPED;
               emit               = 1'b1;
               result.option_kind = b;
               result.walk_status = itow_pkg::STATUS_OVERRUN;
            end else begin
               next_state.pending_kind = b;
               next_state.position     = base.position + 6'd1;
               next_state.bytes_left   = base.bytes_left - 6'd1;
               next_state.phase        = itow_pkg::PH_LEN;
            end
         end
         itow_pkg::PH_LEN: begin
            emit                 = 1'b1;
            result.option_kind   = base.pending_kind;
            result.option_length = b;
            if (b < itow_pkg::MIN_OPTION_LEN) begin
               next_state.phase   = itow_pkg::PH_STOPPED;
               result.walk_status = itow_pkg::STATUS_BADLEN;
            end else if (b > {1'b0, avail}) begin
               next_state.phase      = itow_pkg::PH_STOPPED;
               result.payload_offset = base.position + 6'd1;
               result.walk_status    = itow_pkg::STATUS_OVERRUN;
            end else begin
               next_state.position   = base.position + 6'd1;
               next_state.bytes_left = base.bytes_left - 6'd1;
               next_state.skip_count = b - itow_pkg::MIN_OPTION_LEN;
               next_state.phase      = (b == itow_pkg::MIN_OPTION_LEN)
                                       ? itow_pkg::PH_KIND : itow_pkg::PH_SKIP;
               result.payload_offset = base.position + 6'd1;
            end
         end
         itow_pkg::PH_SKIP: begin
            next_state.skip_count = skip_dec;
            next_state.bytes_left = (base.bytes_left != '0)
                                    ? base.bytes_left - 6'd1 : base.bytes_left;
            next_state.position   = base.position + 6'd1;
            if (skip_dec == 8'd0) begin
               next_state.phase = itow_pkg::PH_KIND;
            end
         end
         default: begin
            next_state = base;
         end
      endcase
   end

endmodule
